@@ rtl/base64url_decoder_assert.svh @@
// assertion macros shared by the decoder modules
`ifndef BASE64URL_DECODER_ASSERT_SVH
`define BASE64URL_DECODER_ASSERT_SVH

`ifndef SYNTH
// property checked on every clock edge outside reset
`define B64D_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
// condition in one cycle implies a result in the next
`define B64D_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define B64D_ASSERT(lbl, prop, msg)
`define B64D_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

@@ rtl/b64d_pkg.sv @@
package b64d_pkg;

   // command codes
   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // result status codes
   localparam logic [1:0] ST_DATA         = 2'd0;
   localparam logic [1:0] ST_END_OK       = 2'd1;
   localparam logic [1:0] ST_END_BAD      = 2'd2;
   localparam logic [1:0] ST_END_DANGLING = 2'd3;

   // default depth of the job queue
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic        command;
      logic [15:0] character_code;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic [1:0] status;
      logic       last_of_run;
   } rsp_type;

   // one unit of work for the back end: up to three bytes, or an end sequence
   typedef struct packed {
      logic [23:0] data;
      logic [1:0]  count;
      logic        is_end;
      logic [1:0]  end_status;
   } job_type;

   localparam int JOB_W = $bits(job_type);

   // alphabet lookup: bit 6 set means not in the alphabet
   function automatic logic [6:0] sextet_of(input logic [15:0] code);
      logic [6:0] v;
      v = 7'd64;
      if (code >= 16'h0041 && code <= 16'h005A) begin
         v = 7'(code - 16'h0041);
      end else if (code >= 16'h0061 && code <= 16'h007A) begin
         v = 7'(code - 16'h0061 + 16'd26);
      end else if (code >= 16'h0030 && code <= 16'h0039) begin
         v = 7'(code - 16'h0030 + 16'd52);
      end else if (code == 16'h002D) begin
         v = 7'd62;
      end else if (code == 16'h005F) begin
         v = 7'd63;
      end
      return v;
   endfunction

   // tab, line feed, carriage return, space
   function automatic logic is_space(input logic [15:0] code);
      return code == 16'd9 || code == 16'd10 || code == 16'd13 || code == 16'd32;
   endfunction

endpackage

@@ rtl/b64d_fifo.sv @@
`include "base64url_decoder_assert.svh"

module b64d_fifo #(
   parameter int WIDTH = 29,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = cnt_ff == CNT_W'(DEPTH);
   assign empty     = cnt_ff == '0;
   assign head_data = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `B64D_ASSERT(a_no_overflow, !(push && full), "job pushed into a full queue")
   `B64D_ASSERT(a_cnt_range, cnt_ff <= CNT_W'(DEPTH), "queue occupancy out of range")

endmodule

@@ rtl/b64d_front.sv @@
`include "base64url_decoder_assert.svh"

module b64d_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  b64d_pkg::req_type req_data,
   input  logic              q_full,
   output logic              q_push,
   output b64d_pkg::job_type q_job
);
   import b64d_pkg::*;

   logic [17:0] held_ff, held_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic        failed_ff, failed_in;
   logic        accept;
   logic [6:0]  sext;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign sext      = sextet_of(req_data.character_code);

   // classify the beat, update pending sextets, build a job
   always_comb begin
      held_in       = held_ff;
      held_count_in = held_count_ff;
      failed_in     = failed_ff;
      q_push        = 1'b0;
      q_job         = '0;
      if (accept) begin
         if (req_data.command == CMD_END) begin
            q_push       = 1'b1;
            q_job.is_end = 1'b1;
            priority if (failed_ff) begin
               q_job.count      = 2'd1;
               q_job.end_status = ST_END_BAD;
            end else begin
               unique case (held_count_ff)
                  2'd1: begin
                     q_job.count      = 2'd1;
                     q_job.end_status = ST_END_DANGLING;
                  end
                  2'd2: begin
                     q_job.count      = 2'd2;
                     q_job.data       = {held_ff[11:4], 16'd0};
                     q_job.end_status = ST_END_OK;
                  end
                  2'd3: begin
                     q_job.count      = 2'd3;
                     q_job.data       = {held_ff[17:2], 8'd0};
                     q_job.end_status = ST_END_OK;
                  end
                  default: begin
                     q_job.count      = 2'd1;
                     q_job.end_status = ST_END_OK;
                  end
               endcase
            end
            held_in       = '0;
            held_count_in = '0;
            failed_in     = 1'b0;
         end else if (!is_space(req_data.character_code) && !failed_ff) begin
            if (sext[6]) begin
               failed_in = 1'b1;
            end else if (held_count_ff == 2'd3) begin
               q_push        = 1'b1;
               q_job.data    = {held_ff, sext[5:0]};
               q_job.count   = 2'd3;
               held_in       = '0;
               held_count_in = '0;
            end else begin
               held_in       = {held_ff[11:0], sext[5:0]};
               held_count_in = held_count_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         held_count_ff <= '0;
         failed_ff     <= 1'b0;
      end else begin
         held_ff       <= held_in;
         held_count_ff <= held_count_in;
         failed_ff     <= failed_in;
      end
   end

   `B64D_ASSERT_NEXT(a_end_clears, accept && req_data.command == CMD_END, held_count_ff == 2'd0 && !failed_ff, "end beat left state behind")

endmodule

@@ rtl/b64d_back.sv @@
`include "base64url_decoder_assert.svh"

module b64d_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  b64d_pkg::job_type q_job,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output b64d_pkg::rsp_type rsp_data
);
   import b64d_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       load, last;
   logic [7:0] pick;

   assign load = !q_empty && (!rsp_valid_ff || rsp_ready);
   assign last = idx_ff == (q_job.count - 2'd1);

   // byte of the current job at the current index
   always_comb begin
      unique case (idx_ff)
         2'd0:    pick = q_job.data[23:16];
         2'd1:    pick = q_job.data[15:8];
         2'd2:    pick = q_job.data[7:0];
         default: pick = 8'd0;
      endcase
   end

   // step through the job, one result a cycle while a job is queued and the output is not stalled
   always_comb begin
      rsp_in       = rsp_ff;
      idx_in       = idx_ff;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.last_of_run = last;
         if (q_job.is_end && last) begin
            rsp_in.byte_value = 8'd0;
            rsp_in.status     = q_job.end_status;
         end else begin
            rsp_in.byte_value = pick;
            rsp_in.status     = ST_DATA;
         end
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
         q_pop  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register, no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `B64D_ASSERT(a_job_count, q_empty || q_job.count != 2'd0, "queued job with no results")
   `B64D_ASSERT(a_status_last, !rsp_valid_ff || rsp_ff.status == ST_DATA || rsp_ff.last_of_run, "end status not on last beat")

endmodule

@@ rtl/base64url_decoder.sv @@
// channel  dir  handshake              payload
// req_     in   req_valid / req_ready  req_data  (command, character_code)
// rsp_     out  rsp_valid / rsp_ready  rsp_data  (byte_value, status, last_of_run)
//
// one character beat is taken per cycle while the job queue has room
// results leave one per cycle from the output register while rsp_ready is high; a full group or an
// end beat becomes one queued job that gives one to three results
// the rate of four characters for three bytes keeps the output side in step
// reset is synchronous: pending sextets, failure flag, queue and output valid flag clear
// a stall on rsp_ready backs up the queue; req_ready drops only when it is full

module base64url_decoder #(
   parameter int QDEPTH = b64d_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  b64d_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output b64d_pkg::rsp_type rsp_data
);
   import b64d_pkg::*;

   logic    q_push, q_pop, q_full, q_empty;
   job_type push_job, head_job;

   // character classification and group assembly
   b64d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   // job queue between the two halves
   b64d_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (QDEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_job),
      .pop       (q_pop),
      .head_data (head_job),
      .full      (q_full),
      .empty     (q_empty)
   );

   // result sequencing and output register
   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (head_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/sv/base64url_decoder_checker.sv @@
`timescale 1ns / 100ps

module base64url_decoder_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  b64d_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  b64d_pkg::rsp_type rsp_data,
   output int                mismatches,
   output int                outstanding,
   output int                bytes_decoded,
   output int                texts_closed,
   output int                texts_failed
);
   import b64d_pkg::*;

   // decoder state mirrored on the prediction side
   logic [17:0] held_bits;
   logic [1:0]  held_n;
   logic        text_broken;
   rsp_type     decoded_q[$];
   int          err_total;
   int          byte_total;
   int          close_total;
   int          fail_total;

   // sextet for an alphabet character, bit 6 set for anything else
   function automatic logic [6:0] alphabet_index(input logic [15:0] code);
      logic [6:0] idx;
      idx = 7'd64;
      if (code >= 16'h0041 && code <= 16'h005A) begin
         idx = 7'(code - 16'h0041);
      end else if (code >= 16'h0061 && code <= 16'h007A) begin
         idx = 7'(code - 16'h0061) + 7'd26;
      end else if (code >= 16'h0030 && code <= 16'h0039) begin
         idx = 7'(code - 16'h0030) + 7'd52;
      end else if (code == 16'h002D) begin
         idx = 7'd62;
      end else if (code == 16'h005F) begin
         idx = 7'd63;
      end
      return idx;
   endfunction

   // append one predicted result beat
   task automatic queue_result(input rsp_type r);
      decoded_q = {decoded_q, r};
   endtask

   // unused and empty; predict_beat below turns one accepted request beat into its results
   task automatic decode_beat(input rsp_type unused_dummy, input req_type beat);
   endtask

   task automatic predict_beat(input req_type beat);
      logic [6:0]  sx;
      logic [23:0] group;
      logic [15:0] code;
      code = beat.character_code;
      if (beat.command == CMD_CHAR) begin
         // whitespace and anything after a bad character are dropped
         if (code == 16'd9 || code == 16'd10 || code == 16'd13 || code == 16'd32) return;
         if (text_broken) return;
         sx = alphabet_index(code);
         if (sx[6]) begin
            text_broken = 1'b1;
            return;
         end
         if (held_n == 2'd3) begin
            group = {held_bits, sx[5:0]};
            queue_result(rsp_type'{group[23:16], ST_DATA, 1'b0});
            queue_result(rsp_type'{group[15:8], ST_DATA, 1'b0});
            queue_result(rsp_type'{group[7:0], ST_DATA, 1'b1});
            held_bits = '0;
            held_n    = 2'd0;
         end else begin
            held_bits = {held_bits[11:0], sx[5:0]};
            held_n    = held_n + 2'd1;
         end
      end else begin
         // end of text: flush the partial group, then one status
         if (text_broken) begin
            queue_result(rsp_type'{8'h00, ST_END_BAD, 1'b1});
         end else begin
            case (held_n)
               2'd1: begin
                  queue_result(rsp_type'{8'h00, ST_END_DANGLING, 1'b1});
               end
               2'd2: begin
                  queue_result(rsp_type'{held_bits[11:4], ST_DATA, 1'b0});
                  queue_result(rsp_type'{8'h00, ST_END_OK, 1'b1});
               end
               2'd3: begin
                  queue_result(rsp_type'{held_bits[17:10], ST_DATA, 1'b0});
                  queue_result(rsp_type'{held_bits[9:2], ST_DATA, 1'b0});
                  queue_result(rsp_type'{8'h00, ST_END_OK, 1'b1});
               end
               default: begin
                  queue_result(rsp_type'{8'h00, ST_END_OK, 1'b1});
               end
            endcase
         end
         held_bits   = '0;
         held_n      = 2'd0;
         text_broken = 1'b0;
      end
   endtask

   // compare a result beat against the oldest prediction
   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (decoded_q.size() == 0) begin
         if (err_total < 10) begin
            $display("%0t: unexpected result byte %02h status %0d last %0b",
                     $realtime, got.byte_value, got.status, got.last_of_run);
         end
         err_total++;
         return;
      end
      want = decoded_q.pop_front();
      if (want.byte_value != got.byte_value || want.status != got.status ||
          want.last_of_run != got.last_of_run) begin
         if (err_total < 10) begin
            $write("%0t: mismatch expected byte %02h status %0d last %0b,",
                   $realtime, want.byte_value, want.status, want.last_of_run);
            $display(" got byte %02h status %0d last %0b",
                     got.byte_value, got.status, got.last_of_run);
         end
         err_total++;
      end
      if (got.status == ST_DATA) byte_total++;
      else close_total++;
      if (got.status == ST_END_BAD || got.status == ST_END_DANGLING) fail_total++;
   endtask

   initial begin
      held_bits   = '0;
      held_n      = 2'd0;
      text_broken = 1'b0;
      err_total   = 0;
      byte_total  = 0;
      close_total = 0;
      fail_total  = 0;
   end

   // results leave before this edge's request can affect anything
   always @(posedge clock) begin
      if (reset) begin
         held_bits   = '0;
         held_n      = 2'd0;
         text_broken = 1'b0;
         decoded_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (req_valid && req_ready) predict_beat(req_data);
      end
      mismatches    <= err_total;
      outstanding   <= decoded_q.size();
      bytes_decoded <= byte_total;
      texts_closed  <= close_total;
      texts_failed  <= fail_total;
   end

endmodule

@@ tb/sv/base64url_decoder_tb.sv @@
`timescale 1ns / 100ps

module base64url_decoder_tb;
   import b64d_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int      mismatches;
   int      outstanding;
   int      bytes_decoded;
   int      texts_closed;
   int      texts_failed;

   logic    calm;
   logic    hold_request;
   int      quiet_cycles;
   int      beats_sent;

   base64url_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   base64url_decoder_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .bytes_decoded (bytes_decoded),
      .texts_closed  (texts_closed),
      .texts_failed  (texts_failed)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // alphabet character for a sextet value
   function automatic logic [15:0] sextet_char(input int unsigned s);
      if (s < 26) return 16'(16'h0041 + s);
      if (s < 52) return 16'(16'h0061 + s - 26);
      if (s < 62) return 16'(16'h0030 + s - 52);
      if (s == 62) return 16'h002D;
      return 16'h005F;
   endfunction

   function automatic logic [15:0] space_char();
      case ($urandom_range(3))
         0: return 16'd9;
         1: return 16'd10;
         2: return 16'd13;
         default: return 16'd32;
      endcase
   endfunction

   // codes outside the alphabet, low and wide
   function automatic logic [15:0] bad_char();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'h003D;
         2: return 16'h002B;
         3: return 16'h002F;
         4: return 16'h007F;
         5: return 16'($urandom_range(16'h0008, 16'h0001));
         6: return 16'($urandom_range(16'h007E, 16'h007B));
         default: return 16'($urandom_range(16'hFFFF, 16'h0080));
      endcase
   endfunction

   // offer one request beat, at times with a random gap ahead of it
   task automatic offer_beat(input logic cmd, input logic [15:0] code);
      @(negedge clock);
      if (!calm && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req_type'{cmd, code};
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   task automatic offer_text(input string s);
      for (int i = 0; i < s.len(); i++) offer_beat(CMD_CHAR, {8'h00, s[i]});
   endtask

   // result side: random back-pressure, plus one long hold-off on request
   initial begin
      int stall_left;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready  <= 1'b0;
            stall_left = HOLD_CYCLES;
            while (stall_left > 0) begin
               @(negedge clock);
               stall_left--;
            end
            hold_request = 1'b0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 30);
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // stimulus and verdict
   initial begin
      int  text_len;
      int  bad_at;
      bit  broken;
      bit  pressure_done;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      calm         = 1'b0;
      hold_request = 1'b0;
      beats_sent   = 0;
      pressure_done = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed texts: empty, full groups, short tails, whitespace, bad codes
      offer_beat(CMD_END, 16'hFFFF);
      offer_text("_-09AzZa");
      offer_beat(CMD_END, 16'h0000);
      offer_text("Q\tR");
      offer_beat(CMD_END, 16'h0000);
      offer_text("8 x");
      offer_beat(CMD_CHAR, 16'h000D);
      offer_text("_");
      offer_beat(CMD_END, 16'h0000);
      offer_text("g\n");
      offer_beat(CMD_END, 16'h0000);
      offer_text("A");
      offer_beat(CMD_CHAR, 16'h0000);
      offer_text("B");
      offer_beat(CMD_END, 16'h0000);
      offer_beat(CMD_CHAR, 16'hFFFF);
      offer_beat(CMD_END, 16'h0000);

      // random texts, mostly well formed, some with a bad character
      while (beats_sent < 280) begin
         text_len  = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(11);
         broken    = ($urandom_range(9) == 0);
         bad_at    = $urandom_range(text_len);
         for (int i = 0; i <= text_len; i++) begin
            if (!pressure_done && beats_sent >= 100) begin
               hold_request  = 1'b1;
               pressure_done = 1'b1;
            end
            calm = (beats_sent >= 160 && beats_sent < 220);
            if ($urandom_range(9) == 0) offer_beat(CMD_CHAR, space_char());
            if (broken && i == bad_at) offer_beat(CMD_CHAR, bad_char());
            if (i < text_len) offer_beat(CMD_CHAR, sextet_char($urandom_range(63)));
         end
         offer_beat(CMD_END, 16'($urandom_range(16'hFFFF)));
      end
      calm = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then wait for any stray results
      do @(posedge clock); while (outstanding != 0);
      repeat (20) @(posedge clock);

      $display("covered %0d texts (%0d ended bad or dangling) and %0d data bytes,",
               texts_closed, texts_failed, bytes_decoded);
      $display("with whitespace, wide codes, partial groups and a long result stall");
      if (mismatches == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
